// ===== rtl/scs_pkg.sv =====
`timescale 1ns / 1ps

package scs_pkg;

    // Characters the scanner looks for
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_NL     = 8'h0A;

    // Scanner mode
    typedef enum logic [2:0] {
        MODE_NORMAL = 3'd0,
        MODE_SLASH  = 3'd1,
        MODE_LINE   = 3'd2,
        MODE_BLOCK  = 3'd3,
        MODE_BSTAR  = 3'd4,
        MODE_STRING = 3'd5,
        MODE_ESCAPE = 3'd6
    } scs_mode_t;

    // One result item
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       run_last;
        logic       stream_end;
    } scs_res_t;

    // All results of one input byte: r0 always, r1 only when two is set
    typedef struct packed {
        scs_res_t r0;
        scs_res_t r1;
        logic     two;
    } scs_pair_t;

endpackage

// ===== rtl/scs_in_if.sv =====
`timescale 1ns / 1ps

interface scs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       text_end;

    modport source (output valid, output in_byte, output text_end, input ready);
    modport sink (input valid, input in_byte, input text_end, output ready);
endinterface

// ===== rtl/scs_out_if.sv =====
`timescale 1ns / 1ps

interface scs_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       run_last;
    logic       stream_end;

    modport source (
        output valid, output out_byte, output byte_valid,
        output run_last, output stream_end, input ready
    );
    modport sink (
        input valid, input out_byte, input byte_valid,
        input run_last, input stream_end, output ready
    );
endinterface

// ===== rtl/scs_scan.sv =====
`timescale 1ns / 1ps

module scs_scan (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [7:0]        in_byte,
    input  logic              text_end,
    output scs_pkg::scs_pair_t pair,
    output logic              has_res
);

    scs_pkg::scs_mode_t mode_reg;
    scs_pkg::scs_mode_t mode_next;
    scs_pkg::scs_mode_t mode_scan;
    logic               quote_reg;
    logic               quote_next;
    logic               quote_scan;
    logic [7:0]         closer;
    logic               emit_held;
    logic               emit_byte;
    logic               emit_tail;
    logic               any_emit;

    assign closer = quote_reg ? scs_pkg::CH_SQUOTE : scs_pkg::CH_DQUOTE;

    // Decide the next mode and which bytes go out
    always_comb
    begin
        mode_scan  = mode_reg;
        quote_scan = quote_reg;
        emit_held  = 1'b0;
        emit_byte  = 1'b0;
        case (mode_reg)
            scs_pkg::MODE_SLASH:
            begin
                if (in_byte == scs_pkg::CH_SLASH)
                begin
                    mode_scan = scs_pkg::MODE_LINE;
                end
                else if (in_byte == scs_pkg::CH_STAR)
                begin
                    mode_scan = scs_pkg::MODE_BLOCK;
                end
                else
                begin
                    // No comment: release the held slash, then treat as text
                    emit_held = 1'b1;
                    emit_byte = 1'b1;
                    mode_scan = scs_pkg::MODE_NORMAL;
                    if (in_byte == scs_pkg::CH_DQUOTE || in_byte == scs_pkg::CH_SQUOTE)
                    begin
                        quote_scan = (in_byte == scs_pkg::CH_SQUOTE);
                        mode_scan  = scs_pkg::MODE_STRING;
                    end
                end
            end
            scs_pkg::MODE_LINE:
            begin
                if (in_byte == scs_pkg::CH_NL)
                begin
                    mode_scan = scs_pkg::MODE_NORMAL;
                    emit_byte = 1'b1;
                end
            end
            scs_pkg::MODE_BLOCK:
            begin
                if (in_byte == scs_pkg::CH_STAR)
                begin
                    mode_scan = scs_pkg::MODE_BSTAR;
                end
            end
            scs_pkg::MODE_BSTAR:
            begin
                if (in_byte == scs_pkg::CH_SLASH)
                begin
                    mode_scan = scs_pkg::MODE_NORMAL;
                end
                else if (in_byte != scs_pkg::CH_STAR)
                begin
                    mode_scan = scs_pkg::MODE_BLOCK;
                end
            end
            scs_pkg::MODE_STRING:
            begin
                emit_byte = 1'b1;
                if (in_byte == scs_pkg::CH_BSLASH)
                begin
                    mode_scan = scs_pkg::MODE_ESCAPE;
                end
                else if (in_byte == closer)
                begin
                    mode_scan = scs_pkg::MODE_NORMAL;
                end
            end
            scs_pkg::MODE_ESCAPE:
            begin
                emit_byte = 1'b1;
                mode_scan = scs_pkg::MODE_STRING;
            end
            default:
            begin
                mode_scan = scs_pkg::MODE_NORMAL;
                if (in_byte == scs_pkg::CH_DQUOTE || in_byte == scs_pkg::CH_SQUOTE)
                begin
                    quote_scan = (in_byte == scs_pkg::CH_SQUOTE);
                    mode_scan  = scs_pkg::MODE_STRING;
                    emit_byte  = 1'b1;
                end
                else if (in_byte == scs_pkg::CH_SLASH)
                begin
                    mode_scan = scs_pkg::MODE_SLASH;
                end
                else
                begin
                    emit_byte = 1'b1;
                end
            end
        endcase
    end

    // Flush a held slash at end of text and return to reset state
    assign emit_tail  = text_end && (mode_scan == scs_pkg::MODE_SLASH);
    assign mode_next  = text_end ? scs_pkg::MODE_NORMAL : mode_scan;
    assign quote_next = text_end ? 1'b0 : quote_scan;
    assign any_emit   = emit_held | emit_byte | emit_tail;
    assign has_res    = any_emit | text_end;

    // Pack the results in output order
    always_comb
    begin
        pair.two           = emit_held & emit_byte;
        pair.r0.byte_valid = any_emit;
        if (emit_held || emit_tail)
        begin
            pair.r0.out_byte = scs_pkg::CH_SLASH;
        end
        else if (emit_byte)
        begin
            pair.r0.out_byte = in_byte;
        end
        else
        begin
            pair.r0.out_byte = 8'h00;
        end
        pair.r0.run_last   = ~pair.two;
        pair.r0.stream_end = text_end;
        pair.r1.out_byte   = in_byte;
        pair.r1.byte_valid = 1'b1;
        pair.r1.run_last   = 1'b1;
        pair.r1.stream_end = text_end;
    end

    // Hold the scan state between bytes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= scs_pkg::MODE_NORMAL;
            quote_reg <= 1'b0;
        end
        else if (step)
        begin
            mode_reg  <= mode_next;
            quote_reg <= quote_next;
        end
    end

`ifndef SYNTH
    a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
        step && text_end |=> mode_reg == scs_pkg::MODE_NORMAL && !quote_reg)
        else $error("scan state not reset after end of text");

    a_escape_back: assert property (@(posedge clk) disable iff (!rst_n)
        step && !text_end && mode_reg == scs_pkg::MODE_ESCAPE
        |=> mode_reg == scs_pkg::MODE_STRING)
        else $error("escaped byte did not return to string mode");

    a_quote_held: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> $stable(quote_reg) && $stable(mode_reg))
        else $error("scan state moved without a byte");
`endif

endmodule

// ===== rtl/scs_out.sv =====
`timescale 1ns / 1ps

module scs_out (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  scs_pkg::scs_pair_t pair,
    output logic               pair_free,
    scs_out_if.source          dout
);

    logic               pr_vld_reg;
    logic               pr_vld_next;
    logic               idx_reg;
    logic               idx_next;
    scs_pkg::scs_pair_t pr_reg;
    scs_pkg::scs_res_t  cur;
    logic               xfer;

    assign cur  = idx_reg ? pr_reg.r1 : pr_reg.r0;
    assign xfer = pr_vld_reg && dout.ready;

    // Free once the last result of the held item transfers
    assign pair_free = !pr_vld_reg || (dout.ready && (idx_reg || !pr_reg.two));

    assign dout.valid      = pr_vld_reg;
    assign dout.out_byte   = cur.out_byte;
    assign dout.byte_valid = cur.byte_valid;
    assign dout.run_last   = cur.run_last;
    assign dout.stream_end = cur.stream_end;

    // Advance to the second result or take the next item
    always_comb
    begin
        pr_vld_next = pr_vld_reg;
        idx_next    = idx_reg;
        if (xfer && !idx_reg && pr_reg.two)
        begin
            idx_next = 1'b1;
        end
        else if (pair_free)
        begin
            pr_vld_next = load;
            idx_next    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pr_vld_reg <= 1'b0;
            idx_reg    <= 1'b0;
        end
        else
        begin
            pr_vld_reg <= pr_vld_next;
            idx_reg    <= idx_next;
        end
    end

    // Payload: capture with each new item
    always_ff @(posedge clk)
    begin
        if (pair_free && load)
        begin
            pr_reg <= pair;
        end
    end

`ifndef SYNTH
    a_second_follows: assert property (@(posedge clk) disable iff (!rst_n)
        xfer && !idx_reg && pr_reg.two |=> pr_vld_reg && idx_reg)
        else $error("second result lost");

    a_second_only_pair: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg |-> pr_vld_reg && pr_reg.two)
        else $error("second slot selected on a single result");

    a_bare_marker: assert property (@(posedge clk) disable iff (!rst_n)
        dout.valid && !dout.byte_valid |-> dout.run_last && dout.stream_end)
        else $error("bare result is not an end marker");
`endif

endmodule

// ===== rtl/source_comment_stripper_top.sv =====
`timescale 1ns / 1ps

// Channel    Role   Payload
// text_in    sink   in_byte[7:0], text_end
// text_out   source out_byte[7:0], byte_valid, run_last, stream_end
//
// One byte per cycle in and one result per cycle out of the result
// register, while text_out is ready. A byte that releases a held slash
// gives two results, so the input is held until the second is sent.
// The first result passes the input register, then the result register.
// rst_n clears the scan state and all valid flags; the next byte starts a text.

module source_comment_stripper_top (
    input  logic      clk,
    input  logic      rst_n,
    scs_in_if.sink    text_in,
    scs_out_if.source text_out
);

    logic               in_vld_reg;
    logic               in_vld_next;
    logic [7:0]         in_byte_reg;
    logic               in_end_reg;
    logic               pair_free;
    logic               adv;
    logic               has_res;
    scs_pkg::scs_pair_t pair;

    // Move the registered byte on when the result stage can take it
    assign adv           = in_vld_reg && pair_free;
    assign text_in.ready = !in_vld_reg || pair_free;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (text_in.valid && text_in.ready)
        begin
            in_vld_next = 1'b1;
        end
        else if (adv)
        begin
            in_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg <= in_vld_next;
        end
    end

    // Capture the byte on each input transfer
    always_ff @(posedge clk)
    begin
        if (text_in.valid && text_in.ready)
        begin
            in_byte_reg <= text_in.in_byte;
            in_end_reg  <= text_in.text_end;
        end
    end

    scs_scan u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (adv),
        .in_byte  (in_byte_reg),
        .text_end (in_end_reg),
        .pair     (pair),
        .has_res  (has_res)
    );

    scs_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (adv && has_res),
        .pair      (pair),
        .pair_free (pair_free),
        .dout      (text_out)
    );

endmodule
